// File: sv/gn2t_pkg.sv
`timescale 1ns / 1ps
package gn2t_pkg;

    localparam int TABLE_DEPTH_DEF     = 256;
    localparam int MAX_OCTAVE_LOG2_DEF = 16;

    // field and register widths
    localparam int PERIOD_W  = 9;
    localparam int OCTAVE_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W   = 8;
    localparam int COORD_W   = 32;
    localparam int NOISE_W   = 40;
    localparam int FRAC_W    = 16;

    // shared multiplier widths
    localparam int MUL_AW = 34;
    localparam int MUL_BW = 22;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE = 2'd1;

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_RDA,
        S_MODA,
        S_RDH,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

endpackage

// File: sv/gradient_noise_2d_turbulence.sv
`timescale 1ns / 1ps
// evaluate: prefix state PRE from bit J = max(32, 16 + MAX_OCTAVE_LOG2) down to 16 + L,
//   then RDA, MODA, RDH, MUL, ACC per octave (L octaves, one when L = 0), then DONE
// throughput: one request at a time, bound by the single multiplier and single table read port
// load requests are written on acceptance and leave the block idle
// reset: synchronous active low, period = 256, octave_log2 = 0, table contents kept
module gradient_noise_2d_turbulence
    import gn2t_pkg::*;
#(
    parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
    parameter int MAX_OCTAVE_LOG2 = MAX_OCTAVE_LOG2_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    // request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [79:0]          s_axis_tdata,  // entry_index, entry_value, x_coord, y_coord
    input  logic                 s_axis_tuser,  // req_type
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [NOISE_W-1:0]   m_axis_tdata   // noise_out
);

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int PW   = $clog2(TABLE_DEPTH + 1);
    localparam int LW   = $clog2(MAX_OCTAVE_LOG2 + 1);
    // bit position the prefix starts from; above bit 31 only sign bits
    localparam int JMAX = (16 + MAX_OCTAVE_LOG2 > COORD_W) ? 16 + MAX_OCTAVE_LOG2 : COORD_W;
    localparam int JW   = $clog2(JMAX + 1);
    localparam int ACCW = 24 + MAX_OCTAVE_LOG2 + 6;

    localparam logic signed [ACCW-1:0] OUT_MAX = ACCW'(40'sh7FFFFFFFFF);
    localparam logic signed [ACCW-1:0] OUT_MIN = ACCW'(40'sh8000000000);

    // one step of a bit-serial remainder: (2r + b) mod p, r < p
    function automatic logic [PW-1:0] mod_step(input logic [PW-1:0] r, input logic b,
                                               input logic [PW-1:0] p);
        logic [PW:0] t;
        t = {r, b};
        if (t >= {1'b0, p}) begin
            t = t - {1'b0, p};
        end
        return t[PW-1:0];
    endfunction

    // (a + b) mod p for a, b < p
    function automatic logic [AW-1:0] mod_add(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                              input logic [PW-1:0] p);
        logic [PW:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, p}) begin
            t = t - {1'b0, p};
        end
        return AW'(t);
    endfunction

    // diagonal gradient dot product
    function automatic logic signed [18:0] corner(input logic [1:0] h,
                                                  input logic signed [17:0] dx,
                                                  input logic signed [17:0] dy);
        logic signed [18:0] ex;
        logic signed [18:0] ey;
        ex = 19'(dx);
        ey = 19'(dy);
        case (h)
            2'd0:    return ex + ey;
            2'd1:    return ey - ex;
            2'd2:    return -ex - ey;
            default: return ex - ey;
        endcase
    endfunction

    // configuration
    logic [PERIOD_W-1:0] r_period;
    logic [OCTAVE_W-1:0] r_octave;

    // sequencer
    t_state r_state, n_state;
    logic [4:0] r_cnt;

    // per-request context
    logic [PW-1:0]       r_p;
    logic [LW-1:0]       r_lim;
    logic [LW-1:0]       r_k;
    logic [JW-1:0]       r_j;
    logic [JW-1:0]       r_jstop;
    logic [JMAX-1:0]     r_xs;
    logic [JMAX-1:0]     r_ys;
    logic [PW-1:0]       r_cx;
    logic [PW-1:0]       r_cy;
    logic [ENTRY_W-1:0]  r_a0;
    logic [ENTRY_W-1:0]  r_a1;
    logic [PW-1:0]       r_a0m;
    logic [PW-1:0]       r_a1m;
    logic [1:0]          r_h [4];  // bl, br, tl, tr

    // fade and blend intermediates
    logic [31:0]         r_t2x, r_t2y;
    logic [15:0]         r_t3x, r_t3y;
    logic [20:0]         r_in16x, r_in16y;
    logic [20:0]         r_u, r_v;
    logic signed [20:0]  r_l0, r_l1;
    logic signed [23:0]  r_val;
    logic signed [ACCW-1:0] r_acc;

    // output register
    logic                r_out_valid;
    logic [NOISE_W-1:0]  r_out_data;

    // combinational helpers
    logic [PW-1:0]       cx1, cy1;
    logic [FRAC_W-1:0]   fx, fy;
    logic signed [17:0]  dx0, dx1, dy0, dy1;
    logic signed [18:0]  dbl, dbr, dtl, dtr;
    logic [3:0]          op;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic signed [MUL_PW-1:0] p_sh;
    logic [37:0]         inner_x, inner_y;
    logic signed [23:0]  n_sum;
    logic [23:0]         abs_val;
    logic signed [ACCW-1:0] acc_sum;
    logic                last_oct;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                ram_we;
    logic                in_acc;
    logic [PW-1:0]       p_eff;
    logic [LW-1:0]       lim_eff;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign ram_we = in_acc && (s_axis_tuser == REQ_LOAD)
                    && (32'(s_axis_tdata[7:0]) < TABLE_DEPTH);

    assign p_eff   = (r_period == '0) ? PW'(1)
                   : (32'(r_period) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(r_period);
    assign lim_eff = (32'(r_octave) > MAX_OCTAVE_LOG2) ? LW'(MAX_OCTAVE_LOG2) : LW'(r_octave);

    assign cx1 = (r_cx + PW'(1) == r_p) ? '0 : r_cx + PW'(1);
    assign cy1 = (r_cy + PW'(1) == r_p) ? '0 : r_cy + PW'(1);

    // fraction bits 15+k..k sit at the top of the remaining coordinate bits
    assign fx  = r_xs[JMAX-1 -: FRAC_W];
    assign fy  = r_ys[JMAX-1 -: FRAC_W];
    assign dx0 = 18'($signed({2'b00, fx}));
    assign dy0 = 18'($signed({2'b00, fy}));
    assign dx1 = dx0 - 18'sd65536;
    assign dy1 = dy0 - 18'sd65536;
    assign dbl = corner(r_h[0], dx0, dy0);
    assign dbr = corner(r_h[1], dx1, dy0);
    assign dtl = corner(r_h[2], dx0, dy1);
    assign dtr = corner(r_h[3], dx1, dy1);

    // fade inner term 6t^2 - 15t*2^16 + 10*2^32, always positive on [0,1)
    assign inner_x = (38'(r_t2x) << 2) + (38'(r_t2x) << 1) - (38'(fx) << 20)
                   + (38'(fx) << 16) + 38'd42949672960;
    assign inner_y = (38'(r_t2y) << 2) + (38'(r_t2y) << 1) - (38'(fy) << 20)
                   + (38'(fy) << 16) + 38'd42949672960;

    // even count issues a product, odd count writes it back
    assign op = r_cnt[4:1];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            4'd0: begin
                mul_a = MUL_AW'($signed({1'b0, fx}));
                mul_b = MUL_BW'($signed({1'b0, fx}));
            end
            4'd1: begin
                mul_a = MUL_AW'($signed({1'b0, r_t2x}));
                mul_b = MUL_BW'($signed({1'b0, fx}));
            end
            4'd2: begin
                mul_a = MUL_AW'($signed({1'b0, r_t3x}));
                mul_b = MUL_BW'($signed({1'b0, r_in16x}));
            end
            4'd3: begin
                mul_a = MUL_AW'($signed({1'b0, fy}));
                mul_b = MUL_BW'($signed({1'b0, fy}));
            end
            4'd4: begin
                mul_a = MUL_AW'($signed({1'b0, r_t2y}));
                mul_b = MUL_BW'($signed({1'b0, fy}));
            end
            4'd5: begin
                mul_a = MUL_AW'($signed({1'b0, r_t3y}));
                mul_b = MUL_BW'($signed({1'b0, r_in16y}));
            end
            4'd6: begin
                mul_a = MUL_AW'(20'(dtl) - 20'(dbl));
                mul_b = MUL_BW'($signed({1'b0, r_v}));
            end
            4'd7: begin
                mul_a = MUL_AW'(20'(dtr) - 20'(dbr));
                mul_b = MUL_BW'($signed({1'b0, r_v}));
            end
            4'd8: begin
                mul_a = MUL_AW'(22'(r_l1) - 22'(r_l0));
                mul_b = MUL_BW'($signed({1'b0, r_u}));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gn2t_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // floor division by 2^16 of the blend product
    assign p_sh  = mul_p >>> 16;
    assign n_sum = 24'(p_sh + MUL_PW'(r_l0));

    assign abs_val  = r_val[23] ? 24'(-r_val) : 24'(r_val);
    assign acc_sum  = r_acc + ((ACCW'(abs_val)) << r_k);
    assign last_oct = (r_lim == '0) || (r_k == LW'(1));

    // table read address by phase
    always_comb begin
        ram_raddr = AW'(r_cx);
        case (r_state)
            S_RDA: begin
                ram_raddr = (r_cnt == 5'd0) ? AW'(r_cx) : AW'(cx1);
            end
            S_RDH: begin
                case (r_cnt[1:0])
                    2'd0:    ram_raddr = mod_add(r_a0m, r_cy, r_p);
                    2'd1:    ram_raddr = mod_add(r_a1m, r_cy, r_p);
                    2'd2:    ram_raddr = mod_add(r_a0m, cy1, r_p);
                    default: ram_raddr = mod_add(r_a1m, cy1, r_p);
                endcase
            end
            default: ram_raddr = AW'(r_cx);
        endcase
    end

    gn2t_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(s_axis_tdata[7:0])),
        .i_wdata (s_axis_tdata[15:8]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && s_axis_tuser == REQ_EVAL) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                if (r_j == r_jstop) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                if (r_cnt == 5'd2) begin
                    n_state = S_MODA;
                end
            end
            S_MODA: begin
                if (r_cnt == 5'd7) begin
                    n_state = S_RDH;
                end
            end
            S_RDH: begin
                if (r_cnt == 5'd4) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == 5'd17) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = last_oct ? S_DONE : S_RDA;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(256);
            r_octave <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_OCTAVE: r_octave <= i_cfg_data[OCTAVE_W-1:0];
                default: ;
            endcase
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (n_state != r_state) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 5'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // sign bits above the word stand for floor(x / 2^JMAX) = -1 or 0
                r_p     <= p_eff;
                r_lim   <= lim_eff;
                r_k     <= lim_eff;
                r_j     <= JW'(JMAX);
                r_jstop <= JW'(16) + JW'(lim_eff);
                r_xs    <= JMAX'($signed(s_axis_tdata[47:16]));
                r_ys    <= JMAX'($signed(s_axis_tdata[79:48]));
                r_cx    <= s_axis_tdata[47] ? p_eff - PW'(1) : '0;
                r_cy    <= s_axis_tdata[79] ? p_eff - PW'(1) : '0;
                r_acc   <= '0;
            end
            S_PRE: begin
                if (r_j != r_jstop) begin
                    r_cx <= mod_step(r_cx, r_xs[JMAX-1], r_p);
                    r_cy <= mod_step(r_cy, r_ys[JMAX-1], r_p);
                    r_xs <= r_xs << 1;
                    r_ys <= r_ys << 1;
                    r_j  <= r_j - JW'(1);
                end
            end
            S_RDA: begin
                r_a0m <= '0;
                r_a1m <= '0;
                if (r_cnt == 5'd1) begin
                    r_a0 <= ram_rdata;
                end
                if (r_cnt == 5'd2) begin
                    r_a1 <= ram_rdata;
                end
            end
            S_MODA: begin
                // table values reduced modulo the period, one bit a cycle
                r_a0m <= mod_step(r_a0m, r_a0[ENTRY_W-1], r_p);
                r_a1m <= mod_step(r_a1m, r_a1[ENTRY_W-1], r_p);
                r_a0  <= r_a0 << 1;
                r_a1  <= r_a1 << 1;
            end
            S_RDH: begin
                if (r_cnt != 5'd0) begin
                    r_h[2'(r_cnt[2:0] - 3'd1)] <= ram_rdata[1:0];
                end
            end
            S_MUL: begin
                if (r_cnt[0]) begin
                    case (op)
                        4'd0: r_t2x <= mul_p[31:0];
                        4'd1: begin
                            r_t3x   <= mul_p[47:32];
                            r_in16x <= inner_x[36:16];
                        end
                        4'd2: r_u   <= mul_p[36:16];
                        4'd3: r_t2y <= mul_p[31:0];
                        4'd4: begin
                            r_t3y   <= mul_p[47:32];
                            r_in16y <= inner_y[36:16];
                        end
                        4'd5: r_v  <= mul_p[36:16];
                        4'd6: r_l0 <= 21'(p_sh + MUL_PW'(dbl));
                        4'd7: r_l1 <= 21'(p_sh + MUL_PW'(dbr));
                        4'd8: r_val <= (n_sum >>> 1) + 24'sd32768;
                        default: ;
                    endcase
                end
            end
            S_ACC: begin
                if (r_lim == '0) begin
                    r_acc <= ACCW'(r_val);
                end else begin
                    r_acc <= acc_sum;
                end
                if (!last_oct) begin
                    // next finer octave: one more bit into the cell remainder
                    r_cx <= mod_step(r_cx, r_xs[JMAX-1], r_p);
                    r_cy <= mod_step(r_cy, r_ys[JMAX-1], r_p);
                    r_xs <= r_xs << 1;
                    r_ys <= r_ys << 1;
                    r_k  <= r_k - LW'(1);
                end
            end
            default: ;
        endcase
    end

    // output register, saturated to the 40-bit range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
            if (r_acc > OUT_MAX) begin
                r_out_data <= NOISE_W'(OUT_MAX);
            end else if (r_acc < OUT_MIN) begin
                r_out_data <= NOISE_W'(OUT_MIN);
            end else begin
                r_out_data <= NOISE_W'(r_acc);
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // an evaluate request holds off the next request
    a_busy_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_EVAL |=> !s_axis_tready)
        else $error("ready after evaluate request");

    // cell remainders stay below the period while working
    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_cx < r_p && r_cy < r_p)
        else $error("cell index out of period");

    // octave counter stays within the requested range
    a_octave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE && r_lim != '0 |-> r_k >= LW'(1) && r_k <= r_lim)
        else $error("octave counter out of range");

endmodule

// File: sv/gn2t_ram.sv
`timescale 1ns / 1ps
module gn2t_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/gn2t_mul.sv
`timescale 1ns / 1ps
module gn2t_mul
    import gn2t_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_AW-1:0] i_a,
    input  logic signed [MUL_BW-1:0] i_b,
    output logic signed [MUL_PW-1:0] o_p
);

    logic signed [MUL_PW-1:0] r_p;

    // registered signed product
    always_ff @(posedge i_clk) begin
        r_p <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: dv/tb_gradient_noise_2d_turbulence.sv
`timescale 1ns / 1ps
module tb_gradient_noise_2d_turbulence
    import gn2t_pkg::*;
();

    localparam longint SUM_MAX   = 64'sd549755813887;
    localparam int     DRAIN_CYC = 700;    // longer than one evaluate at the deepest octave
    localparam int     WDOG_MAX  = 20000;  // idle cycles before the run is declared hung

    typedef struct {
        logic               kind;
        logic [7:0]         idx;
        logic [7:0]         val;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_req;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [PERIOD_W-1:0]  i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [79:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [NOISE_W-1:0]   m_axis_tdata;

    t_req               cur_req = '{REQ_LOAD, 8'd0, 8'd0, 32'sd0, 32'sd0};
    t_req               pending_reqs[$];
    logic [NOISE_W-1:0] expected_noise[$];
    logic [7:0]         perm_copy[256];
    int                 period_copy = 256;
    int                 octave_copy = 0;
    int                 idle_mode = 0;  // 0: sender rarely idles, 1: receiver rarely idles, 2: none
    int                 hold_left = 0;
    int                 mismatches = 0;
    int                 wdog = 0;
    bit                 req_taken = 1'b0;

    // tdata fields from the lowest bit: entry_index, entry_value, x_coord, y_coord
    assign s_axis_tdata = {cur_req.y, cur_req.x, cur_req.val, cur_req.idx};
    assign s_axis_tuser = cur_req.kind;

    gradient_noise_2d_turbulence i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // quintic fade on a Q16 fraction
    function automatic longint fade(longint t);
        longint t3, poly;
        t3   = (t * t * t) >>> 32;
        poly = (6 * t * t - 15 * t * 65536 + 10 * 64'sd4294967296) >>> 16;
        return (t3 * poly) >>> 16;
    endfunction

    function automatic longint lerp16(longint w, longint a, longint b);
        return a + ((w * (b - a)) >>> 16);
    endfunction

    function automatic longint grad_dot(logic [7:0] h, longint dx, longint dy);
        case (h[1:0])
            2'd0:    return dx + dy;
            2'd1:    return -dx + dy;
            2'd2:    return -dx - dy;
            default: return dx - dy;
        endcase
    endfunction

    function automatic longint wrap_mod(longint c, longint p);
        longint r;
        r = c % p;
        if (r < 0) r += p;
        return r;
    endfunction

    // one octave of gradient noise, already mapped to value/2 + 1/2
    function automatic longint octave_noise(longint x, longint y, int k, longint p);
        int     sh;
        longint fmask, cx, cy, fx, fy, x1, y1, a0, a1, n;
        logic [7:0] htr, htl, hbr, hbl;
        sh    = 16 + k;
        fmask = (64'sd1 <<< sh) - 1;
        cx    = wrap_mod(x >>> sh, p);
        cy    = wrap_mod(y >>> sh, p);
        fx    = (x & fmask) >>> k;
        fy    = (y & fmask) >>> k;
        x1    = (cx + 1) % p;
        y1    = (cy + 1) % p;
        a0    = perm_copy[cx];
        a1    = perm_copy[x1];
        htr   = perm_copy[(a1 + y1) % p];
        htl   = perm_copy[(a0 + y1) % p];
        hbr   = perm_copy[(a1 + cy) % p];
        hbl   = perm_copy[(a0 + cy) % p];
        n = lerp16(fade(fx),
                   lerp16(fade(fy), grad_dot(hbl, fx, fy), grad_dot(htl, fx, fy - 65536)),
                   lerp16(fade(fy), grad_dot(hbr, fx - 65536, fy),
                          grad_dot(htr, fx - 65536, fy - 65536)));
        return (n >>> 1) + 32768;
    endfunction

    function automatic logic [NOISE_W-1:0] turbulence(t_req r);
        longint p, x, y, v, sum;
        int     lim;
        p   = (period_copy < 1) ? 1 : (period_copy > 256) ? 256 : period_copy;
        lim = (octave_copy > 16) ? 16 : octave_copy;
        x   = r.x;
        y   = r.y;
        if (lim == 0) begin
            sum = octave_noise(x, y, 0, p);
        end else begin
            sum = 0;
            for (int k = lim; k >= 1; k--) begin
                v = octave_noise(x, y, k, p);
                if (v < 0) v = -v;
                sum += v <<< k;
            end
        end
        if (sum > SUM_MAX) sum = SUM_MAX;
        return sum[NOISE_W-1:0];
    endfunction

    // request acceptance: update the table copy or queue the expected noise value
    always @(posedge i_clk) begin
        req_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            if (cur_req.kind == REQ_LOAD)
                perm_copy[cur_req.idx] = cur_req.val;
            else
                expected_noise.push_back(turbulence(cur_req));
        end
    end

    // request driver, changes at the falling edge
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || req_taken) begin
            if (pending_reqs.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(99) < 7) &&
                !(idle_mode == 1 && $urandom_range(99) < 60)) begin
                cur_req       <= pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_mode == 0) begin
            m_axis_tready <= ($urandom_range(99) >= 60);
        end else if (idle_mode == 1) begin
            m_axis_tready <= ($urandom_range(99) >= 7);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_noise.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise_out=%h", m_axis_tdata);
            end else begin
                if (m_axis_tdata !== expected_noise[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise_out mismatch: expected %h actual %h",
                                 expected_noise[0], m_axis_tdata);
                end
                void'(expected_noise.pop_front());
            end
        end
    end

    // hang detection: no handshake and no register write for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("FAIL gradient_noise_2d_turbulence");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_PERIOD)
            period_copy = data;
        else if (idx == CFG_OCTAVE)
            octave_copy = data[OCTAVE_W-1:0];
    endtask

    task automatic push_load(logic [7:0] idx, logic [7:0] val);
        pending_reqs.push_back('{REQ_LOAD, idx, val, $urandom, $urandom});
    endtask

    task automatic push_eval(logic signed [31:0] x, logic signed [31:0] y);
        pending_reqs.push_back('{REQ_EVAL, 8'($urandom), 8'($urandom), x, y});
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(32'h00200000)) - 32'sh00100000;
            2:       return $signed({16'($urandom_range(511)), 16'h0000}) - 32'sh01000000;
            default: return {16'($urandom_range(65535)), 16'h0000} | 32'($urandom_range(65535));
        endcase
    endfunction

    // wait until every request went in and every result came out, then let loads settle
    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_noise.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // register values per phase: period write, octave write, random request count
    int ph_period[10] = '{256, 1,   0, 511, 17,  256, 200, 64, 3,   256};
    int ph_octave[10] = '{0,   0,   0, 1,   2,   3,   16,  31, 0,   1};
    int ph_count[10]  = '{100, 60, 40, 60,  200, 150, 12,  8,  200, 200};

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // every entry is written before the first evaluate reads the table
        for (int i = 0; i < 256; i++)
            push_load(i[7:0], 8'($urandom_range(255)));
        // field extremes and table corner entries
        push_load(8'd0, 8'hFF);
        push_load(8'd255, 8'h00);
        push_eval(32'sh00000000, 32'sh00000000);
        push_eval(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        push_eval(32'sh80000000, 32'sh80000000);
        push_eval(-32'sd1, -32'sd1);
        push_eval(32'sh00010000, 32'sh0000FFFF);
        push_eval(32'sh80000000, 32'sh7FFFFFFF);
        push_eval(32'sh00FF0000, 32'shFF00FFFF);
        drain();

        // unknown register indexes are ignored by the block
        cfg_write(2'd2, 9'h1FF);
        cfg_write(2'd3, 9'h000);

        for (int ph = 0; ph < 10; ph++) begin
            idle_mode = (ph < 3) ? 0 : (ph < 6) ? 1 : 2;
            cfg_write(CFG_PERIOD, PERIOD_W'(ph_period[ph]));
            cfg_write(CFG_OCTAVE, PERIOD_W'(ph_octave[ph]));
            for (int n = 0; n < ph_count[ph]; n++) begin
                if ($urandom_range(99) < 20)
                    push_load(8'($urandom_range(255)), 8'($urandom_range(255)));
                else
                    push_eval(rand_coord(), rand_coord());
            end
            // long receiver hold-off while requests keep coming, to back up the input
            if (ph == 8) begin
                @(posedge i_clk);
                hold_left = 1500;
            end
            drain();
        end

        if (mismatches == 0)
            $display("PASS gradient_noise_2d_turbulence");
        else
            $display("FAIL gradient_noise_2d_turbulence");
        $finish;
    end

endmodule
